/* sv/sm3_pkg.sv */
// Shared constants, types and round functions for the SM3 hash engine.
package sm3_pkg;

  localparam int QDEPTH = 16;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [31:0] T_LOW    = 32'h79CC4519;
  localparam logic [31:0] T_HIGH   = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [0:7][31:0] IV = {
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  // one big-endian message word on its way from front to back
  typedef struct packed {
    logic [31:0] word;
    logic        last;   // final word of a padded message
  } qword_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    rol32 = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    perm0 = x ^ rol32(x, 9) ^ rol32(x, 17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    perm1 = x ^ rol32(x, 15) ^ rol32(x, 23);
  endfunction

endpackage

/* sv/sm3_front.sv */
// Front end: takes message bytes, appends padding and length, packs words.
module sm3_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      s_axis_tdata,   // [7:0] data_byte
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic            s_axis_tlast,   // final_byte
  output sm3_pkg::qword_t q_wdata,
  output logic            q_push,
  input  logic            q_full
);
  import sm3_pkg::*;

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_PAD80   = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_LEN     = 2'd3;

  logic [1:0]  state;
  logic [5:0]  pos;       // byte position within the 64-byte block
  logic [60:0] byte_cnt;  // message length in bytes, wraps with the bit count
  logic [23:0] acc;       // earlier bytes of the word being packed

  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic        byte_go;
  logic [7:0]  byte_val;

  assign bit_len  = {byte_cnt, 3'b000};
  assign len_byte = 8'(bit_len >> {~pos[2:0], 3'b000});

  always_comb begin
    byte_go  = 1'b0;
    byte_val = 8'h00;
    case (state)
      ST_COLLECT: begin
        byte_go  = s_axis_tvalid && !q_full;
        byte_val = s_axis_tdata;
      end
      ST_PAD80: begin
        byte_go  = !q_full;
        byte_val = PAD_BYTE;
      end
      ST_ZERO: begin
        byte_go  = !q_full && (pos != 6'd56);
        byte_val = 8'h00;
      end
      ST_LEN: begin
        byte_go  = !q_full;
        byte_val = len_byte;
      end
      default: begin
        byte_go  = 1'b0;
        byte_val = 8'h00;
      end
    endcase
  end

  assign s_axis_tready = (state == ST_COLLECT) && !q_full;
  assign q_push        = byte_go && (pos[1:0] == 2'd3);
  assign q_wdata.word  = {acc, byte_val};
  assign q_wdata.last  = (state == ST_LEN) && (pos == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_COLLECT;
      pos      <= 6'd0;
      byte_cnt <= '0;
    end else begin
      if (byte_go) begin
        pos <= pos + 6'd1;
        acc <= {acc[15:0], byte_val};
      end
      case (state)
        ST_COLLECT: begin
          if (byte_go) begin
            byte_cnt <= byte_cnt + 61'd1;
            if (s_axis_tlast) state <= ST_PAD80;
          end
        end
        ST_PAD80: begin
          if (byte_go) state <= ST_ZERO;
        end
        ST_ZERO: begin
          if (pos == 6'd56) state <= ST_LEN;
        end
        ST_LEN: begin
          if (byte_go && (pos == 6'd63)) begin
            state    <= ST_COLLECT;
            byte_cnt <= '0;
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

endmodule

/* sv/sm3_queue.sv */
// Word queue between the packing front end and the compression back end.
module sm3_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sm3_pkg::qword_t wdata,
  output logic            full,
  input  logic            pop,
  output sm3_pkg::qword_t rdata,
  output logic            empty
);
  import sm3_pkg::*;

  qword_t         mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;    // words held in the array
  logic           rvalid;   // rdata holds a word
  logic           load;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = !rvalid;
  // refill the output word whenever it is free or leaving this cycle
  assign load  = (count != '0) && (!rvalid || pop);

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
    if (load) rdata <= mem[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      count  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (load) rptr <= rptr + 1'b1;
      if (load) begin
        rvalid <= 1'b1;
      end else if (pop) begin
        rvalid <= 1'b0;
      end
      case ({push, load})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/sm3_back.sv */
// Back end: loads 16 words, runs 64 rounds with on-the-fly expansion, emits digest.
module sm3_back (
  input  logic            clk,
  input  logic            rst,
  input  sm3_pkg::qword_t q_rdata,
  input  logic            q_empty,
  output logic            q_pop,
  output logic [39:0]     m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic            m_axis_tlast    // last_word
);
  import sm3_pkg::*;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;

  logic [1:0]  state;
  logic [5:0]  cnt;        // load word count, then round number
  logic [2:0]  oidx;
  logic        blk_last;
  logic [31:0] tj;         // round constant already rotated by the round number
  logic [31:0] w     [16]; // w[0] is W[j]
  logic [31:0] v     [8];
  logic [31:0] chain [8];

  logic [31:0] nv [8];
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, wnew, w_in;
  logic        early;

  always_comb begin
    early = (cnt[5:4] == 2'd0);
    a12   = rol32(v[0], 12);
    ss1   = rol32(a12 + v[4] + tj, 7);
    ss2   = ss1 ^ a12;
    ff    = early ? (v[0] ^ v[1] ^ v[2])
                  : ((v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]));
    gg    = early ? (v[4] ^ v[5] ^ v[6]) : ((v[4] & v[5]) | (~v[4] & v[6]));
    tt1   = ff + v[3] + ss2 + (w[0] ^ w[4]);
    tt2   = gg + v[7] + ss1 + w[0];
    nv[0] = tt1;
    nv[1] = v[0];
    nv[2] = rol32(v[1], 9);
    nv[3] = v[2];
    nv[4] = perm0(tt2);
    nv[5] = v[4];
    nv[6] = rol32(v[5], 19);
    nv[7] = v[6];
    // W[j+16] from the window W[j..j+15]
    wnew  = perm1(w[0] ^ w[7] ^ rol32(w[13], 15)) ^ rol32(w[3], 7) ^ w[10];
    w_in  = (state == ST_LOAD) ? q_rdata.word : wnew;
  end

  assign q_pop         = (state == ST_LOAD) && !q_empty;
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {5'b00000, oidx, chain[oidx]};
  assign m_axis_tlast  = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (q_pop || (state == ST_ROUND)) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= 6'd0;
      oidx  <= 3'd0;
      for (int i = 0; i < 8; i++) chain[i] <= IV[i];
    end else begin
      case (state)
        ST_LOAD: begin
          if (q_pop) begin
            cnt <= cnt + 6'd1;
            if (cnt == 6'd15) begin
              cnt      <= 6'd0;
              blk_last <= q_rdata.last;
              tj       <= T_LOW;
              for (int i = 0; i < 8; i++) v[i] <= chain[i];
              state    <= ST_ROUND;
            end
          end
        end
        ST_ROUND: begin
          for (int i = 0; i < 8; i++) v[i] <= nv[i];
          tj  <= (cnt == 6'd15) ? {T_HIGH[15:0], T_HIGH[31:16]} : rol32(tj, 1);
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            for (int i = 0; i < 8; i++) chain[i] <= chain[i] ^ nv[i];
            state <= blk_last ? ST_OUT : ST_LOAD;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int i = 0; i < 8; i++) chain[i] <= IV[i];
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

/* sv/sm3_hash_top.sv */
// Top level of the SM3 hash engine: byte stream in, eight digest words out.
//
// Message bytes enter one per cycle on the slave stream while the queue has room, tlast
// marking the final byte. The front end packs bytes into words and, after the final
// byte, generates the 0x80 pad, zeros and the 64-bit length (9 to 72 extra bytes) at
// one byte per cycle, also while the queue has room. A 16-word queue feeds the back
// end, which loads a block of 16 words and then runs 64 rounds, one round per cycle in
// a single round unit. After the last block the eight digest words leave in order,
// index 0 first, tlast on index 7, and the chaining value returns to the standard
// initial value. Bytes of the next message may arrive while the digest drains.
module sm3_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tlast,   // final_byte
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tlast    // last_word
);
  import sm3_pkg::*;

  qword_t q_wdata;
  qword_t q_rdata;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;

  sm3_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .q_wdata       (q_wdata),
    .q_push        (q_push),
    .q_full        (q_full)
  );

  sm3_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sm3_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_rdata       (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("word pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("word popped from empty queue");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !q_full)
    else $error("byte taken with no queue room");

  a_digest_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("digest output continued past last word");

endmodule
